### sv/hpc_pkg.sv
// Package for the hysteresis pulse counter: sizes, register codes and the
// control bundle handed from the top level to the counter cells.
// No dependencies.
package hpc_pkg;

	// channel row and counter sizes
	localparam int NUM_CHANNELS = 32;
	localparam int COUNT_BITS   = 32;
	localparam int IDX_BITS     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// payload field widths
	localparam int CH_BITS     = 5;
	localparam int SAMPLE_BITS = 12;
	localparam int OUT_BITS    = 32;

	// APB register map
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	typedef enum logic {
		REG_RISE = 1'b0,
		REG_FALL = 1'b1
	} hpc_reg_t;

	localparam logic [SAMPLE_BITS-1:0] RISE_RESET = SAMPLE_BITS'(500);
	localparam logic [SAMPLE_BITS-1:0] FALL_RESET = SAMPLE_BITS'(450);

	// request kinds
	typedef enum logic {
		REQ_SAMPLE  = 1'b0,
		REQ_READOUT = 1'b1
	} hpc_req_t;

	// thresholds as held by the register block
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] rise;
		logic [SAMPLE_BITS-1:0] fall;
	} hpc_cfg_t;

	// broadcast to every cell each cycle
	typedef struct packed {
		logic                   shift;
		logic [SAMPLE_BITS-1:0] sample;
		hpc_cfg_t               cfg;
	} hpc_cell_ctrl_t;

endpackage

### sv/hpc_if.sv
// Valid/ready channel interfaces for request beats and count beats.
// Depends on hpc_pkg for field widths.
interface hpc_in_if import hpc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [CH_BITS-1:0]     channel;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, req_type, channel, sample, input ready);
	modport sink   (input valid, req_type, channel, sample, output ready);
endinterface

interface hpc_out_if import hpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CH_BITS-1:0]  out_channel;
	logic [OUT_BITS-1:0] pulse_count;
	logic                last;

	modport source (output valid, out_channel, pulse_count, last, input ready);
	modport sink   (input valid, out_channel, pulse_count, last, output ready);
endinterface

### sv/hpc_cfg.sv
// APB register block holding the rise and fall thresholds.
// Depends on hpc_pkg.
module hpc_cfg import hpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output hpc_cfg_t             cfg
);

	hpc_cfg_t cfg_q;
	hpc_reg_t sel_reg;
	logic     wr_en;

	assign pready  = 1'b1;
	assign sel_reg = hpc_reg_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise <= RISE_RESET;
			cfg_q.fall <= FALL_RESET;
		end else if (wr_en) begin
			case (sel_reg)
				REG_RISE: cfg_q.rise <= pwdata[SAMPLE_BITS-1:0];
				REG_FALL: cfg_q.fall <= pwdata[SAMPLE_BITS-1:0];
				default:  ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (sel_reg)
			REG_RISE: prdata = DATA_BITS'(cfg_q.rise);
			REG_FALL: prdata = DATA_BITS'(cfg_q.fall);
			default:  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### sv/hpc_cell.sv
// One channel of the counter row: hysteresis flag and saturating count.
// On readout the count moves one cell toward the output end each shift.
// Depends on hpc_pkg.
module hpc_cell import hpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hpc_cell_ctrl_t        ctrl,
	input  logic                  hit,
	input  logic [COUNT_BITS-1:0] next_count,
	output logic [COUNT_BITS-1:0] count
);

	logic                  above_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  rise_ev;
	logic                  fall_ev;

	assign rise_ev = hit && !above_q && (ctrl.sample > ctrl.cfg.rise);
	assign fall_ev = hit && above_q && (ctrl.sample < ctrl.cfg.fall);

	// hysteresis flag, kept across readouts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
		end else if (rise_ev) begin
			above_q <= 1'b1;
		end else if (fall_ev) begin
			above_q <= 1'b0;
		end
	end

	// count: shift on readout, saturating increment on a rising pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.shift) begin
			count_q <= next_count;
		end else if (rise_ev && (count_q != '1)) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign count = count_q;

endmodule

### sv/multichannel_hysteresis_pulse_counter_top.sv
// Top level of the hysteresis pulse counter: request decode, the row of
// counter cells, the readout sequencer and the output register.
// Depends on hpc_pkg, hpc_if, hpc_cfg and hpc_cell.
//
//   channel | dir | beat contents                         | handshake
//   --------+-----+---------------------------------------+-----------
//   req     | in  | req_type, channel, sample             | valid/ready
//   res     | out | out_channel, pulse_count, last        | valid/ready
//   apb     | in  | rise_threshold @0x0, fall_threshold @0x4 | pready = 1
//
// A sample beat is taken every cycle while no readout is busy and updates its cell in that cycle.
// A readout beat shifts the cell row toward the output register, one count
// per cycle while the output is not stalled; req.ready is low until the last
// count has been loaded. A stalled output freezes the row.
// Reset clears all flags and counts at once; no clearing pass.
module multichannel_hysteresis_pulse_counter_top import hpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	hpc_in_if.sink               req,
	hpc_out_if.source            res
);

	hpc_cfg_t              cfg;
	hpc_cell_ctrl_t        ctrl;
	logic                  busy_q;
	logic [IDX_BITS-1:0]   rd_idx_q;
	logic                  shift_en;
	logic                  last_idx;
	logic                  req_acc;
	logic                  sample_en;
	logic                  out_valid_q;
	logic [CH_BITS-1:0]    out_ch_q;
	logic [OUT_BITS-1:0]   out_cnt_q;
	logic                  out_last_q;
	logic [COUNT_BITS-1:0] cnt [NUM_CHANNELS];
	logic [COUNT_BITS-1:0] nxt [NUM_CHANNELS];

	hpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request decode
	assign req.ready = !busy_q;
	assign req_acc   = req.valid && req.ready;
	assign sample_en = req_acc && (hpc_req_t'(req.req_type) == REQ_SAMPLE);

	// readout advances when the output register is free or being drained
	assign shift_en = busy_q && (!out_valid_q || res.ready);
	assign last_idx = (rd_idx_q == IDX_BITS'(NUM_CHANNELS - 1));

	assign ctrl.shift  = shift_en;
	assign ctrl.sample = req.sample;
	assign ctrl.cfg    = cfg;

	// cell row, zeros enter at the far end
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		logic hit;

		if (i == NUM_CHANNELS - 1) begin : g_tail
			assign nxt[i] = '0;
		end else begin : g_link
			assign nxt[i] = cnt[i+1];
		end

		assign hit = sample_en && (32'(req.channel) == i);

		hpc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.hit        (hit),
			.next_count (nxt[i]),
			.count      (cnt[i])
		);
	end

	// readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_idx_q <= '0;
		end else if (shift_en) begin
			if (last_idx) begin
				busy_q   <= 1'b0;
				rd_idx_q <= '0;
			end else begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end else if (req_acc && (hpc_req_t'(req.req_type) == REQ_READOUT)) begin
			busy_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift_en) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			out_ch_q   <= CH_BITS'(rd_idx_q);
			out_cnt_q  <= OUT_BITS'(cnt[0]);
			out_last_q <= last_idx;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_channel = out_ch_q;
	assign res.pulse_count = out_cnt_q;
	assign res.last        = out_last_q;

	// readout ends right after the last count is loaded
	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en && last_idx |=> !busy_q)
		else $error("readout still busy after last count");

	// index is parked at zero between runs
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> rd_idx_q == '0)
		else $error("readout index not reset between runs");

	// row is drained to zero once a run completes
	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en && last_idx |=> cnt[0] == '0)
		else $error("counts not cleared by readout");

endmodule

### test/hpc_checker.sv
// Checker for the hysteresis pulse counter: watches the request, count and APB
// traffic, keeps its own copy of thresholds, flags and counts, and compares beats.
// Depends on hpc_pkg and hpc_if.
module hpc_checker import hpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	hpc_in_if                    req_mon,
	hpc_out_if                   res_mon,
	output int                   failures,
	output int                   expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CH_BITS-1:0]  ch;
		logic [OUT_BITS-1:0] count;
		logic                last;
	} count_beat_t;

	logic [SAMPLE_BITS-1:0]  rise_thr;
	logic [SAMPLE_BITS-1:0]  fall_thr;
	logic [NUM_CHANNELS-1:0] is_high;
	logic [COUNT_BITS-1:0]   hit_tally [NUM_CHANNELS];
	count_beat_t             readout_q [$];

	// hysteresis update for a sample, or queue every count for a readout
	task automatic take_request(input logic kind, input logic [CH_BITS-1:0] ch,
			input logic [SAMPLE_BITS-1:0] smp);
		count_beat_t beat;
		if (hpc_req_t'(kind) == REQ_SAMPLE) begin
			if (int'(ch) < NUM_CHANNELS) begin
				if (is_high[ch]) begin
					if (smp < fall_thr)
						is_high[ch] = 1'b0;
				end else if (smp > rise_thr) begin
					// saturate at all ones
					if (hit_tally[ch] != '1)
						hit_tally[ch] = hit_tally[ch] + 1'b1;
					is_high[ch] = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				beat.ch    = CH_BITS'(i);
				beat.count = OUT_BITS'(hit_tally[i]);
				beat.last  = (i == NUM_CHANNELS - 1);
				readout_q.push_back(beat);
				hit_tally[i] = '0;
			end
		end
	endtask

	// compare one count beat with the oldest queued one
	task automatic check_count_beat();
		count_beat_t want;
		if (readout_q.size() == 0) begin
			failures++;
			$display({"%0t: unexpected count beat: expected none, ",
				"actual ch=%0d count=%0d last=%0b"},
				$time, res_mon.out_channel, res_mon.pulse_count, res_mon.last);
		end else begin
			want = readout_q.pop_front();
			if (want.ch !== res_mon.out_channel || want.count !== res_mon.pulse_count ||
					want.last !== res_mon.last) begin
				failures++;
				$display({"%0t: count beat mismatch: expected ch=%0d count=%0d last=%0b, ",
					"actual ch=%0d count=%0d last=%0b"},
					$time, want.ch, want.count, want.last,
					res_mon.out_channel, res_mon.pulse_count, res_mon.last);
			end
		end
	endtask

	// all traffic is sampled on the edge at which it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_thr = RISE_RESET;
			fall_thr = FALL_RESET;
			is_high  = '0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				hit_tally[i] = '0;
			readout_q.delete();
			failures      = 0;
			expected_left = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (hpc_reg_t'(paddr[ADDR_BITS-1:2]))
					REG_RISE: begin
						rise_thr = pwdata[SAMPLE_BITS-1:0];
					end
					REG_FALL: begin
						fall_thr = pwdata[SAMPLE_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (req_mon.valid && req_mon.ready)
				take_request(req_mon.req_type, req_mon.channel, req_mon.sample);
			if (res_mon.valid && res_mon.ready)
				check_count_beat();
			expected_left = readout_q.size();
		end
	end

endmodule

### test/tb_top.sv
// Testbench top for the hysteresis pulse counter: clock, reset, APB writes,
// request and count-side traffic with idling and a long output stall, verdict.
// Depends on hpc_pkg, hpc_if, the counter top level and hpc_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hpc_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_BITS-1:0]   paddr;
	logic [DATA_BITS-1:0]   pwdata;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;
	int                     failures;
	int                     expected_left;
	int                     idle_mode;
	int                     long_stalls;
	logic [SAMPLE_BITS-1:0] cur_rise;
	logic [SAMPLE_BITS-1:0] cur_fall;

	hpc_in_if  req_bus ();
	hpc_out_if res_bus ();

	multichannel_hysteresis_pulse_counter_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_bus),
		.res     (res_bus)
	);

	hpc_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.req_mon       (req_bus),
		.res_mon       (res_bus),
		.failures      (failures),
		.expected_left (expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// idle percentage per side: mode 0 slow receiver, mode 1 slow sender, mode 2 none
	function automatic int idle_pct(input bit sender);
		case (idle_mode)
			0: return sender ? 25 : 57;
			1: return sender ? 57 : 25;
			default: return 0;
		endcase
	endfunction

	// sample values cluster around the thresholds and the extremes
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 5))
			0: v = int'(cur_rise) + int'($urandom_range(0, 3)) - 1;
			1: v = int'(cur_fall) + int'($urandom_range(0, 3)) - 2;
			2: v = 0;
			3: v = 4095;
			default: v = int'($urandom_range(0, 4095));
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return SAMPLE_BITS'(v);
	endfunction

	// count-side ready, with a long hold-off whenever long_stalls moves
	initial begin : count_sink
		int hold_left;
		int stalls_seen;
		hold_left   = 0;
		stalls_seen = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stalls_seen != long_stalls) begin
				stalls_seen = long_stalls;
				hold_left   = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= (int'($urandom_range(0, 99)) >= idle_pct(1'b0));
			end
		end
	end

	// one request beat; returns just after the edge that takes it
	task automatic send_req(input hpc_req_t kind, input logic [CH_BITS-1:0] ch,
			input logic [SAMPLE_BITS-1:0] smp);
		while (int'($urandom_range(0, 99)) < idle_pct(1'b1)) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.channel  <= ch;
		req_bus.sample   <= smp;
		do @(negedge clk); while (!req_bus.ready);
		@(posedge clk);
	endtask

	task automatic sample_beat(input int ch, input int smp);
		send_req(REQ_SAMPLE, CH_BITS'(ch), SAMPLE_BITS'(smp));
	endtask

	task automatic readout_beat();
		send_req(REQ_READOUT, CH_BITS'($urandom_range(0, 31)),
			SAMPLE_BITS'($urandom_range(0, 4095)));
	endtask

	// let every queued count come out and the block settle
	task automatic drain();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input hpc_reg_t which, input logic [SAMPLE_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'({which, 2'b00});
		pwdata  <= {(DATA_BITS-SAMPLE_BITS)'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_thresholds(input int rise, input int fall);
		cur_rise = SAMPLE_BITS'(rise);
		cur_fall = SAMPLE_BITS'(fall);
		apb_write(REG_RISE, cur_rise);
		apb_write(REG_FALL, cur_fall);
	endtask

	// mostly samples on a few busy channels, readouts now and then
	task automatic random_phase(input int n_items, input bit with_hold);
		for (int i = 0; i < n_items; i++) begin
			if (with_hold && i == 12) begin
				long_stalls++;
				readout_beat();
			end else if ($urandom_range(0, 99) < 7) begin
				readout_beat();
			end else if ($urandom_range(0, 1) == 1) begin
				sample_beat($urandom_range(0, 3), pick_sample());
			end else begin
				sample_beat($urandom_range(0, 31), pick_sample());
			end
		end
		drain();
	endtask

	initial begin : stimulus
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_bus.valid    = 1'b0;
		req_bus.req_type = REQ_SAMPLE;
		req_bus.channel  = '0;
		req_bus.sample   = '0;
		idle_mode        = 0;
		long_stalls      = 0;
		cur_rise         = RISE_RESET;
		cur_fall         = FALL_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: rise just above, equal and below on both sides
		readout_beat();
		sample_beat(0, 501);
		sample_beat(0, 500);
		sample_beat(0, 450);
		sample_beat(0, 449);
		sample_beat(0, 4095);
		sample_beat(0, 0);
		sample_beat(31, 4095);
		sample_beat(31, 0);
		sample_beat(5, 500);
		sample_beat(7, 4095);
		readout_beat();
		// high flag survives the readout, so no new count here
		sample_beat(7, 4095);
		readout_beat();
		drain();

		// crossed thresholds at the extremes
		set_thresholds(0, 4095);
		sample_beat(3, 1);
		sample_beat(3, 4094);
		sample_beat(3, 0);
		sample_beat(3, 1);
		sample_beat(3, 4095);
		readout_beat();
		drain();

		// equal thresholds
		set_thresholds(2048, 2048);
		sample_beat(9, 2048);
		sample_beat(9, 2049);
		sample_beat(9, 2048);
		sample_beat(9, 2047);
		readout_beat();
		drain();

		set_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095));
		random_phase(30, 1'b0);
		set_thresholds(4095, 0);
		random_phase(30, 1'b1);

		idle_mode = 1;
		set_thresholds(1000, 1000);
		random_phase(30, 1'b0);
		set_thresholds(500, 450);
		random_phase(30, 1'b0);

		idle_mode = 2;
		set_thresholds($urandom_range(2048, 4095), $urandom_range(0, 2047));
		random_phase(30, 1'b1);

		repeat (NUM_CHANNELS + 8) @(posedge clk);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### multichannel_hysteresis_pulse_counter_top.f
sv/hpc_pkg.sv
sv/hpc_if.sv
sv/hpc_cfg.sv
sv/hpc_cell.sv
sv/multichannel_hysteresis_pulse_counter_top.sv
test/hpc_checker.sv
test/tb_top.sv
